// ===== sv/md4_pkg.sv =====
// md4 digest package: constants, shared types, step tables and the microcode rom
// used by md4_round and md4_message_digest_top; depends on nothing else
package md4_pkg;

  // chaining word initial values and round constants
  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C   = 32'h98BADCFE;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // block geometry
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned LEN_LO_WORD = 14;
  localparam int unsigned LEN_HI_WORD = 15;
  localparam logic [5:0]  LAST_STEP   = 6'd47;
  localparam logic [5:0]  PAD_FIT_MAX = 6'd55;
  localparam logic [2:0]  MAX_BYTES   = 3'd4;

  typedef logic [3:0][31:0] words4_t;
  typedef logic [3:0]       upc_t;

  // datapath operation of one control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ABSORB,
    OP_ROUND,
    OP_FOLD,
    OP_FOLD_TAIL,
    OP_FOLD_CLEAR,
    OP_PAD,
    OP_LENGTH,
    OP_EMIT
  } op_e;

  // jump condition of one control word
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_FULL,
    C_ROUND_BUSY,
    C_NOT_LAST,
    C_FILL_FITS,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  // program addresses
  localparam upc_t UA_WAIT      = 4'd0;
  localparam upc_t UA_ABSORB    = 4'd1;
  localparam upc_t UA_RND_DATA  = 4'd2;
  localparam upc_t UA_TAIL      = 4'd3;
  localparam upc_t UA_TEST      = 4'd4;
  localparam upc_t UA_PAD       = 4'd5;
  localparam upc_t UA_RND_SPILL = 4'd6;
  localparam upc_t UA_CLEAR     = 4'd7;
  localparam upc_t UA_LENGTH    = 4'd8;
  localparam upc_t UA_RND_FINAL = 4'd9;
  localparam upc_t UA_FOLD      = 4'd10;
  localparam upc_t UA_OUT_WAIT  = 4'd11;
  localparam upc_t UA_EMIT      = 4'd12;

  // control rom: the jump is taken when the condition holds, else fall through
  function automatic ucode_t ucode(input upc_t addr);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_WAIT};
    case (addr)
      UA_WAIT:      w = '{op: OP_NOP,        cond: C_NO_INPUT,   target: UA_WAIT};
      UA_ABSORB:    w = '{op: OP_ABSORB,     cond: C_NOT_FULL,   target: UA_TEST};
      UA_RND_DATA:  w = '{op: OP_ROUND,      cond: C_ROUND_BUSY, target: UA_RND_DATA};
      UA_TAIL:      w = '{op: OP_FOLD_TAIL,  cond: C_ALWAYS,     target: UA_TEST};
      UA_TEST:      w = '{op: OP_NOP,        cond: C_NOT_LAST,   target: UA_WAIT};
      UA_PAD:       w = '{op: OP_PAD,        cond: C_FILL_FITS,  target: UA_LENGTH};
      UA_RND_SPILL: w = '{op: OP_ROUND,      cond: C_ROUND_BUSY, target: UA_RND_SPILL};
      UA_CLEAR:     w = '{op: OP_FOLD_CLEAR, cond: C_ALWAYS,     target: UA_LENGTH};
      UA_LENGTH:    w = '{op: OP_LENGTH,     cond: C_ALWAYS,     target: UA_RND_FINAL};
      UA_RND_FINAL: w = '{op: OP_ROUND,      cond: C_ROUND_BUSY, target: UA_RND_FINAL};
      UA_FOLD:      w = '{op: OP_FOLD,       cond: C_ALWAYS,     target: UA_OUT_WAIT};
      UA_OUT_WAIT:  w = '{op: OP_NOP,        cond: C_OUT_FULL,   target: UA_OUT_WAIT};
      UA_EMIT:      w = '{op: OP_EMIT,       cond: C_ALWAYS,     target: UA_WAIT};
      default:      w = '{op: OP_NOP,        cond: C_ALWAYS,     target: UA_WAIT};
    endcase
    return w;
  endfunction

  // message word used by a step: plain, 2x2 transposed, bit reversed
  function automatic logic [3:0] word_index(input logic [5:0] step);
    logic [3:0] i;
    logic [3:0] idx;
    i = step[3:0];
    unique case (step[5:4])
      2'd0:    idx = i;
      2'd1:    idx = {i[1:0], i[3:2]};
      default: idx = {i[0], i[1], i[2], i[3]};
    endcase
    return idx;
  endfunction

  // left rotate amount per round and step within a group of four
  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] pos);
    logic [4:0] amt;
    unique case ({rnd, pos})
      4'b00_00: amt = 5'd3;
      4'b00_01: amt = 5'd7;
      4'b00_10: amt = 5'd11;
      4'b00_11: amt = 5'd19;
      4'b01_00: amt = 5'd3;
      4'b01_01: amt = 5'd5;
      4'b01_10: amt = 5'd9;
      4'b01_11: amt = 5'd13;
      4'b10_00: amt = 5'd3;
      4'b10_01: amt = 5'd9;
      4'b10_10: amt = 5'd11;
      4'b10_11: amt = 5'd15;
      default:  amt = 5'd3;
    endcase
    return amt;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] rnd);
    logic [31:0] k;
    unique case (rnd)
      2'd0:    k = '0;
      2'd1:    k = K_ROUND2;
      default: k = K_ROUND3;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/md4_in_if.sv =====
// message word channel: valid/ready plus one word of message bytes
// uses no package
interface md4_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last;

  modport source (output valid, data_word, valid_bytes, last, input ready);
  modport sink (input valid, data_word, valid_bytes, last, output ready);
endinterface

// ===== sv/md4_out_if.sv =====
// digest channel: valid/ready plus the 16-byte digest in two halves
// uses no package
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_first;
  logic [63:0] digest_second;

  modport source (output valid, digest_first, digest_second, input ready);
  modport sink (input valid, digest_first, digest_second, output ready);
endinterface

// ===== sv/md4_message_digest_top.sv =====
// md4 digest top level: microcode sequencer, byte packing block buffer,
// length count and digest output register; depends on md4_pkg, md4_in_if,
// md4_out_if and md4_round
//
//   channel  dir  payload                          transfer when
//   msg_i    in   data_word, valid_bytes, last     msg_i.valid & msg_i.ready
//   dig_o    out  digest_first, digest_second      dig_o.valid & dig_o.ready
//
// a word that does not fill the block is accepted, packed and tested;
// each filled 64-byte block adds 48 steps of the one round unit
// and a fold into the chaining words.
// the last item adds padding, an extra block if the fill passes 55 bytes,
// the bit length, the final block and its fold, a wait for the output register and the emit.
// reset restores the initial chaining words, zero length and an empty buffer.
// a held digest does not stop input; only a second digest waits for it.
module md4_message_digest_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  md4_in_if.sink    msg_i,
  md4_out_if.source dig_o
);

  // sequencer
  md4_pkg::upc_t    upc_q, upc_d;
  md4_pkg::ucode_t  uw;
  logic             jump;

  // captured item
  logic [31:0]      word_q;
  logic [2:0]       nbytes_q;
  logic             last_q;
  logic [2:0]       nbytes_in;

  // message state
  md4_pkg::words4_t chain_q, chain_d;
  logic [63:0]      bits_q, bits_d;
  logic [5:0]       fill_q, fill_d;
  logic [31:0]      buf_q [md4_pkg::BLOCK_WORDS];
  logic [31:0]      buf_d [md4_pkg::BLOCK_WORDS];
  logic [6:0]       fill_sum;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [63:0]      dig_first_q, dig_second_q;

  // round unit
  logic             rnd_run;
  logic [3:0]       word_sel;
  logic             rnd_final;
  md4_pkg::words4_t rnd_state;

  logic             in_xfer;
  logic             emit;

  assign uw       = md4_pkg::ucode(upc_q);
  assign fill_sum = {1'b0, fill_q} + {4'b0, nbytes_q};
  assign rnd_run  = (uw.op == md4_pkg::OP_ROUND);
  assign emit     = (uw.op == md4_pkg::OP_EMIT);

  assign msg_i.ready = (upc_q == md4_pkg::UA_WAIT);
  assign in_xfer     = msg_i.valid && msg_i.ready;
  assign nbytes_in   = (msg_i.valid_bytes > md4_pkg::MAX_BYTES) ? md4_pkg::MAX_BYTES
                                                                : msg_i.valid_bytes;

  // jump condition and next step address
  always_comb begin
    unique case (uw.cond)
      md4_pkg::C_ALWAYS:     jump = 1'b1;
      md4_pkg::C_NO_INPUT:   jump = !msg_i.valid;
      md4_pkg::C_NOT_FULL:   jump = !fill_sum[6];
      md4_pkg::C_ROUND_BUSY: jump = !rnd_final;
      md4_pkg::C_NOT_LAST:   jump = !last_q;
      md4_pkg::C_FILL_FITS:  jump = (fill_q <= md4_pkg::PAD_FIT_MAX);
      md4_pkg::C_OUT_FULL:   jump = out_valid_q;
      default:               jump = 1'b1;
    endcase
    upc_d = jump ? uw.target : upc_q + 4'd1;
  end

  // compression unit
  md4_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .run_i      (rnd_run),
    .chain_i    (chain_q),
    .msg_word_i (buf_q[word_sel]),
    .word_sel_o (word_sel),
    .final_o    (rnd_final),
    .state_o    (rnd_state)
  );

  // block buffer: byte lanes written by packing, padding and clearing, and the length words
  always_comb begin
    logic [5:0] j;
    logic [5:0] k;
    logic [7:0] item_byte;
    for (int w = 0; w < md4_pkg::BLOCK_WORDS; w++) begin
      buf_d[w] = buf_q[w];
      for (int l = 0; l < md4_pkg::WORD_BYTES; l++) begin
        j         = 6'(w * md4_pkg::WORD_BYTES + l);
        k         = j - fill_q;
        item_byte = word_q[8*k[1:0] +: 8];
        unique case (uw.op)
          md4_pkg::OP_ABSORB: begin
            if (j >= fill_q && k < {3'b0, nbytes_q}) buf_d[w][8*l +: 8] = item_byte;
          end
          md4_pkg::OP_FOLD_TAIL: begin
            if (j < fill_sum[5:0] && k < {3'b0, nbytes_q}) buf_d[w][8*l +: 8] = item_byte;
          end
          md4_pkg::OP_PAD: begin
            if (j == fill_q) begin
              buf_d[w][8*l +: 8] = md4_pkg::PAD_BYTE;
            end else if (j > fill_q) begin
              buf_d[w][8*l +: 8] = '0;
            end
          end
          md4_pkg::OP_FOLD_CLEAR: buf_d[w][8*l +: 8] = '0;
          default: ;
        endcase
      end
      if (uw.op == md4_pkg::OP_LENGTH) begin
        if (w == md4_pkg::LEN_LO_WORD) buf_d[w] = bits_q[31:0];
        if (w == md4_pkg::LEN_HI_WORD) buf_d[w] = bits_q[63:32];
      end
    end
  end

  // chaining words, length and fill
  always_comb begin
    chain_d     = chain_q;
    bits_d      = bits_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !dig_o.ready;
    unique case (uw.op)
      md4_pkg::OP_ABSORB: begin
        bits_d = bits_q + {58'b0, nbytes_q, 3'b0};
        if (!fill_sum[6]) fill_d = fill_sum[5:0];
      end
      md4_pkg::OP_FOLD_TAIL: begin
        for (int i = 0; i < 4; i++) chain_d[i] = chain_q[i] + rnd_state[i];
        fill_d = fill_sum[5:0];
      end
      md4_pkg::OP_FOLD, md4_pkg::OP_FOLD_CLEAR: begin
        for (int i = 0; i < 4; i++) chain_d[i] = chain_q[i] + rnd_state[i];
      end
      md4_pkg::OP_PAD: fill_d = fill_q + 6'd1;
      md4_pkg::OP_EMIT: begin
        chain_d     = {md4_pkg::INIT_D, md4_pkg::INIT_C, md4_pkg::INIT_B, md4_pkg::INIT_A};
        bits_d      = '0;
        fill_d      = '0;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control and message state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= md4_pkg::UA_WAIT;
      chain_q     <= {md4_pkg::INIT_D, md4_pkg::INIT_C, md4_pkg::INIT_B, md4_pkg::INIT_A};
      bits_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      chain_q     <= chain_d;
      bits_q      <= bits_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: captured item, block buffer and digest
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q   <= msg_i.data_word;
      nbytes_q <= nbytes_in;
      last_q   <= msg_i.last;
    end
    for (int w = 0; w < md4_pkg::BLOCK_WORDS; w++) buf_q[w] <= buf_d[w];
    if (emit) begin
      dig_first_q  <= {chain_q[1], chain_q[0]};
      dig_second_q <= {chain_q[3], chain_q[2]};
    end
  end

  assign dig_o.valid         = out_valid_q;
  assign dig_o.digest_first  = dig_first_q;
  assign dig_o.digest_second = dig_second_q;

endmodule

// ===== sv/md4_round.sv =====
// md4 compression unit: working registers, step counter and one step per cycle
// while run_i is high; depends on md4_pkg
module md4_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              run_i,
  input  md4_pkg::words4_t  chain_i,
  input  logic [31:0]       msg_word_i,
  output logic [3:0]        word_sel_o,
  output logic              final_o,
  output md4_pkg::words4_t  state_o
);

  logic [5:0]        step_q, step_d;
  md4_pkg::words4_t  work_q, work_d;
  md4_pkg::words4_t  src;
  logic [1:0]        rnd;
  logic [31:0]       fn;
  logic [31:0]       sum;
  logic [63:0]       rot_wide;
  logic [31:0]       new_word;

  // first step starts from the chaining words
  assign src = (step_q == '0) ? chain_i : work_q;
  assign rnd = step_q[5:4];

  // round function on the three other words
  always_comb begin
    unique case (rnd)
      2'd0:    fn = (src[1] & src[2]) | (~src[1] & src[3]);
      2'd1:    fn = (src[1] & src[2]) | (src[1] & src[3]) | (src[2] & src[3]);
      default: fn = src[1] ^ src[2] ^ src[3];
    endcase
  end

  // add and rotate, then turn the roles so the target always sits in word 0
  assign sum      = src[0] + fn + msg_word_i + md4_pkg::round_const(rnd);
  assign rot_wide = {sum, sum} << md4_pkg::rot_amount(rnd, step_q[1:0]);
  assign new_word = rot_wide[63:32];

  always_comb begin
    work_d = work_q;
    step_d = step_q;
    if (run_i) begin
      work_d = {src[2], src[1], new_word, src[3]};
      step_d = final_o ? '0 : step_q + 6'd1;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // working words
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign word_sel_o = md4_pkg::word_index(step_q);
  assign final_o    = (step_q == md4_pkg::LAST_STEP);
  assign state_o    = work_q;

endmodule
